// ===== hw/rtl/csv_attitude_line_parser_top_defines.svh =====
// Assertion macros shared by the attitude line parser RTL.
// Needs clk and rst in the scope of the module that uses them.
`ifndef CSV_ATTITUDE_LINE_PARSER_TOP_DEFINES_SVH
`define CSV_ATTITUDE_LINE_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CALP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calp check failed");
`define CALP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calp check failed");
`else
`define CALP_ASSERT_IMP(name, ante, cons)
`define CALP_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== hw/rtl/calp_pkg.sv =====
// Types, character codes and fixed-point helpers of the attitude line parser.
// No dependencies.
`default_nettype none
package calp_pkg;

  localparam int PORTS      = 4;
  localparam int PORT_W     = 2;
  localparam int LINE_BYTES = 64;
  localparam int LEN_W      = 6;
  localparam int FRAC_BITS  = 16;

  // integer part saturates here; anything at or above it maps to full scale
  localparam logic [15:0] INT_CAP = 16'd32768;
  // floor(f * 2^16 / 1e5) == (f * RECIP) >> 29 for f < 1e5
  localparam logic [28:0] RECIP = 29'd351843721;
  localparam int RECIP_SH = 29;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_SIGN  = 5'b00010,
    PH_INT   = 5'b00100,
    PH_FRAC  = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_t;

  // weight of a fraction digit in units of 1e-5
  function automatic logic [13:0] frac_weight(input logic [2:0] pos);
    logic [13:0] w;
    begin
      unique case (pos)
        3'd0: w = 14'd10000;
        3'd1: w = 14'd1000;
        3'd2: w = 14'd100;
        3'd3: w = 14'd10;
        default: w = 14'd1;
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/csv_attitude_line_parser_top.sv =====
// Attitude line parser top level: per-port line state, parse and result register.
// Depends on calp_pkg and csv_attitude_line_parser_top_defines.svh.
//
// Usage:
//   Slave channel: one received byte per transfer, s_tdata = byte,
//   s_tuser = receive port. Master channel: one result per committed line
//   (CR or LF ending a non-empty, not overlong line).
//   A byte is registered at its transfer, and the parse writes the result
//   register from the input register when that byte advances.
//   Throughput: one byte per cycle unless a byte that commits a line waits on
//   a stalled result; each byte is parsed by one pass of logic reading its
//   port's state, so bytes of the same port may follow back to back.
//   Reset clears every port's line, the held angles and all counters.
//   When the receiver stalls, the result register holds; bytes that end no
//   line keep flowing, while a line-end byte that commits a line waits in
//   the input register and s_tready drops until the result is taken.
`default_nettype none
`include "csv_attitude_line_parser_top_defines.svh"
module csv_attitude_line_parser_top
  import calp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]   s_tuser,   // [1:0] port_index
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [0] frame_ok, [32:1] pitch_angle, [64:33] roll_angle, [96:65] yaw_angle,
  // [128:97] bytes_seen, [160:129] lines_seen, [192:161] good_lines,
  // [224:193] bad_lines, [232:225] final_byte, [239:233] zero
  output logic [239:0]      m_tdata
);

  // input register
  logic              in_valid;
  logic [PORT_W-1:0] in_port;
  logic [7:0]        in_byte;
  logic              advance;

  // per-port line state
  logic [LEN_W-1:0] line_length   [PORTS];
  logic             overflow_mark [PORTS];
  phase_t           parse_phase   [PORTS];
  logic [1:0]       field_number  [PORTS];
  logic             negative_mark [PORTS];
  logic             digit_seen    [PORTS];
  logic [2:0]       frac_digits   [PORTS];
  logic [15:0]      int_part      [PORTS];
  logic [16:0]      frac_part     [PORTS];
  logic             line_failed   [PORTS];
  logic [31:0]      pending_pitch [PORTS];
  logic [31:0]      pending_roll  [PORTS];

  // shared state
  logic [31:0] held_pitch, held_roll, held_yaw;
  logic [31:0] bytes_seen, lines_seen, good_lines, bad_lines;

  // result register
  logic        out_ok;
  logic [31:0] out_pitch, out_roll, out_yaw;
  logic [31:0] out_bytes, out_lines, out_good, out_bad;
  logic [7:0]  out_byte;

  // next values for the addressed port
  logic [LEN_W-1:0] len_next;
  logic             ovf_next, neg_next, seen_next, failed_next;
  phase_t           phase_next;
  logic [1:0]       field_next;
  logic [2:0]       fd_next;
  logic [15:0]      int_next;
  logic [16:0]      frac_next;
  logic [31:0]      pitch_next, roll_next;
  logic             emit, ok;

  logic             is_numeral, is_space, is_end, is_ctrl;
  logic [3:0]       digit;
  logic [19:0]      int_mac;
  logic [45:0]      frac_prod;
  logic [31:0]      mag, fix_val;
  logic             do_digit, do_comma;
  phase_t           ph;

  // a waiting result only blocks a byte that commits a line
  assign advance  = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_comb begin
    ph         = parse_phase[in_port];
    is_numeral = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    is_space   = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    is_end     = (in_byte == CH_LF) || (in_byte == CH_CR);
    is_ctrl    = (in_byte < CH_SPACE) || (in_byte > CH_TILDE);
    digit      = in_byte[3:0];

    // magnitude to signed Q15.16
    frac_prod = 46'(frac_part[in_port]) * 46'(RECIP);
    if (int_part[in_port] >= INT_CAP) begin
      mag = 32'h7FFF_FFFF;
    end else begin
      mag = {1'b0, int_part[in_port][14:0], frac_prod[RECIP_SH +: FRAC_BITS]};
    end
    fix_val = negative_mark[in_port] ? (32'd0 - mag) : mag;

    int_mac = {int_part[in_port], 3'b000} + {3'b000, int_part[in_port], 1'b0}
              + 20'(digit);

    len_next    = line_length[in_port];
    ovf_next    = overflow_mark[in_port];
    phase_next  = ph;
    field_next  = field_number[in_port];
    neg_next    = negative_mark[in_port];
    seen_next   = digit_seen[in_port];
    fd_next     = frac_digits[in_port];
    int_next    = int_part[in_port];
    frac_next   = frac_part[in_port];
    failed_next = line_failed[in_port];
    pitch_next  = pending_pitch[in_port];
    roll_next   = pending_roll[in_port];
    emit        = 1'b0;
    ok          = 1'b0;
    do_digit    = 1'b0;
    do_comma    = 1'b0;

    // byte classification and per-phase syntax
    priority if (is_end) begin
      emit = !overflow_mark[in_port] && (line_length[in_port] != '0);
      ok   = !line_failed[in_port] && (field_number[in_port] == 2'd2) &&
             digit_seen[in_port] &&
             (ph == PH_INT || ph == PH_FRAC || ph == PH_TRAIL);
    end else if (is_ctrl) begin
    end else if (line_length[in_port] < LEN_W'(LINE_BYTES - 1)) begin
      len_next = line_length[in_port] + LEN_W'(1);
      if (!line_failed[in_port]) begin
        priority if (ph == PH_LEAD || ph == PH_SIGN) begin
          priority if (is_numeral) do_digit = 1'b1;
          else if (in_byte == CH_DOT) phase_next = PH_FRAC;
          else if (ph == PH_LEAD && is_space) begin
          end else if (ph == PH_LEAD && (in_byte == CH_MINUS || in_byte == CH_PLUS)) begin
            neg_next   = (in_byte == CH_MINUS);
            phase_next = PH_SIGN;
          end else failed_next = 1'b1;
        end else if (ph == PH_INT || ph == PH_FRAC) begin
          priority if (is_numeral) do_digit = 1'b1;
          else if (ph == PH_INT && in_byte == CH_DOT) phase_next = PH_FRAC;
          else if (is_space) begin
            if (digit_seen[in_port]) phase_next = PH_TRAIL;
            else failed_next = 1'b1;
          end else if (in_byte == CH_COMMA) do_comma = 1'b1;
          else failed_next = 1'b1;
        end else begin
          priority if (is_space) begin
          end else if (in_byte == CH_COMMA) do_comma = 1'b1;
          else failed_next = 1'b1;
        end
      end
    end else begin
      ovf_next = 1'b1;
    end

    // digit accumulation
    if (do_digit) begin
      seen_next = 1'b1;
      if (ph == PH_FRAC) begin
        if (frac_digits[in_port] < 3'd5) begin
          frac_next = frac_part[in_port]
                      + 17'(18'(digit) * 18'(frac_weight(frac_digits[in_port])));
          fd_next   = frac_digits[in_port] + 3'd1;
        end
      end else begin
        int_next   = (int_mac > 20'(INT_CAP)) ? INT_CAP : int_mac[15:0];
        phase_next = PH_INT;
      end
    end

    // field separator
    if (do_comma) begin
      if (!digit_seen[in_port] || field_number[in_port] == 2'd2) begin
        failed_next = 1'b1;
      end else begin
        if (field_number[in_port] == 2'd0) pitch_next = fix_val;
        else roll_next = fix_val;
        field_next = field_number[in_port] + 2'd1;
        neg_next   = 1'b0;
        seen_next  = 1'b0;
        fd_next    = '0;
        int_next   = '0;
        frac_next  = '0;
        phase_next = PH_LEAD;
      end
    end

    // line end or control byte clears the line
    if (is_end || is_ctrl) begin
      len_next    = '0;
      ovf_next    = 1'b0;
      phase_next  = PH_LEAD;
      field_next  = '0;
      neg_next    = 1'b0;
      seen_next   = 1'b0;
      fd_next     = '0;
      int_next    = '0;
      frac_next   = '0;
      failed_next = 1'b0;
      pitch_next  = '0;
      roll_next   = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_port <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // port state, shared state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORTS; i++) begin
        line_length[i]   <= '0;
        overflow_mark[i] <= 1'b0;
        parse_phase[i]   <= PH_LEAD;
        field_number[i]  <= '0;
        negative_mark[i] <= 1'b0;
        digit_seen[i]    <= 1'b0;
        frac_digits[i]   <= '0;
        int_part[i]      <= '0;
        frac_part[i]     <= '0;
        line_failed[i]   <= 1'b0;
        pending_pitch[i] <= '0;
        pending_roll[i]  <= '0;
      end
      held_pitch <= '0;
      held_roll  <= '0;
      held_yaw   <= '0;
      bytes_seen <= '0;
      lines_seen <= '0;
      good_lines <= '0;
      bad_lines  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (advance) begin
        line_length[in_port]   <= len_next;
        overflow_mark[in_port] <= ovf_next;
        parse_phase[in_port]   <= phase_next;
        field_number[in_port]  <= field_next;
        negative_mark[in_port] <= neg_next;
        digit_seen[in_port]    <= seen_next;
        frac_digits[in_port]   <= fd_next;
        int_part[in_port]      <= int_next;
        frac_part[in_port]     <= frac_next;
        line_failed[in_port]   <= failed_next;
        pending_pitch[in_port] <= pitch_next;
        pending_roll[in_port]  <= roll_next;
        bytes_seen <= bytes_seen + 32'd1;
        if (emit) begin
          lines_seen <= lines_seen + 32'd1;
          if (ok) begin
            held_pitch <= pending_pitch[in_port];
            held_roll  <= pending_roll[in_port];
            held_yaw   <= fix_val;
            good_lines <= good_lines + 32'd1;
          end else begin
            bad_lines <= bad_lines + 32'd1;
          end
          m_tvalid <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_ok    <= ok;
      out_pitch <= ok ? pending_pitch[in_port] : held_pitch;
      out_roll  <= ok ? pending_roll[in_port] : held_roll;
      out_yaw   <= ok ? fix_val : held_yaw;
      out_bytes <= bytes_seen + 32'd1;
      out_lines <= lines_seen + 32'd1;
      out_good  <= ok ? good_lines + 32'd1 : good_lines;
      out_bad   <= ok ? bad_lines : bad_lines + 32'd1;
      out_byte  <= in_byte;
    end
  end

  assign m_tdata = {7'd0, out_byte, out_bad, out_good, out_lines, out_bytes,
                    out_yaw, out_roll, out_pitch, out_ok};

  `CALP_ASSERT_IMP(a_count_split, m_tvalid, out_lines == out_good + out_bad)
  `CALP_ASSERT_IMP(a_ends_line, m_tvalid, out_byte == CH_LF || out_byte == CH_CR)
  `CALP_ASSERT_NXT(a_hold_input, in_valid && !advance, in_valid)
  `CALP_ASSERT_NXT(a_take_input, s_tvalid && s_tready, in_valid)

endmodule
`default_nettype wire
